### design/rsbk_pkg.sv
// rsbk_pkg: shared constants and types of the record sort block
// used by rsbk_cell and record_sort_by_key; depends on nothing
package rsbk_pkg;

	localparam int MAX_RECORDS = 32;
	localparam int PRICE_W     = 32;
	localparam int PAYLOAD_W   = 64;

	typedef logic [PRICE_W-1:0]   price_t;
	typedef logic [PAYLOAD_W-1:0] payload_t;

	typedef struct packed {
		price_t   price;
		payload_t payload;
	} rsbk_rec_t;

	// chain control broadcast to every cell
	typedef struct packed {
		logic load;   // insert the incoming item
		logic shift;  // move every record one cell toward the head
	} rsbk_ctrl_t;

endpackage

### design/record_sort_by_key.sv
// record_sort_by_key: stable ascending sort of records by price key
// instantiates a chain of rsbk_cell; depends on rsbk_pkg
//
// Usage: records enter on the input channel (in_valid/in_stall), one per
// cycle while in_stall is low, each with a 32-bit unsigned price key and a
// 64-bit payload. Every cell of the chain compares the incoming key with its
// own in the same cycle, so a record is inserted as it is taken and the chain
// stays sorted; equal keys keep arrival order. Up to MAX_RECORDS (32) records
// are held, later ones are dropped and the whole set is then output with
// overflowed set. The item with last_record set closes the set. In the cycle
// after it is taken, the output channel (out_valid/out_stall) presents the
// records in ascending key order, one per cycle while out_stall is low, from
// the head cell, last_of_run on the final one. While the set is being emitted
// in_stall is high; it falls in the cycle after the final record is taken.
// A stalled output holds its record in the head cell.
// Reset clears all valid bits and the drop flag; the block then takes input.
module record_sort_by_key (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  rsbk_pkg::price_t    price_key,
	input  rsbk_pkg::payload_t  payload,
	input  logic                last_record,
	output logic                out_valid,
	input  logic                out_stall,
	output rsbk_pkg::price_t    sorted_price,
	output rsbk_pkg::payload_t  sorted_payload,
	output logic                last_of_run,
	output logic                overflowed
);
	import rsbk_pkg::*;

	localparam logic S_LOAD = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic       state_q;
	logic       dropped_q;
	rsbk_ctrl_t ctrl;
	rsbk_rec_t  new_rec;
	logic       in_acc, out_acc, full;

	rsbk_rec_t                cell_rec    [MAX_RECORDS];
	logic [MAX_RECORDS-1:0]   cell_valid;
	logic [MAX_RECORDS-1:0]   cell_before;

	assign new_rec.price   = price_key;
	assign new_rec.payload = payload;

	assign in_stall  = (state_q == S_EMIT);
	assign out_valid = (state_q == S_EMIT);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;
	assign full      = cell_valid[MAX_RECORDS-1];

	assign ctrl.load  = in_acc && !full;
	assign ctrl.shift = out_acc;

	assign sorted_price   = cell_rec[0].price;
	assign sorted_payload = cell_rec[0].payload;
	assign last_of_run    = !cell_valid[1];
	assign overflowed     = dropped_q;

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		rsbk_rec_t l_rec, r_rec;
		logic      l_valid, l_before, r_valid;

		if (i == 0) begin : g_head
			assign l_rec    = '0;
			assign l_valid  = 1'b0;
			assign l_before = 1'b0;
		end else begin : g_mid
			assign l_rec    = cell_rec[i-1];
			assign l_valid  = cell_valid[i-1];
			assign l_before = cell_before[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			assign r_rec   = '0;
			assign r_valid = 1'b0;
		end else begin : g_body
			assign r_rec   = cell_rec[i+1];
			assign r_valid = cell_valid[i+1];
		end

		rsbk_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_rec     (new_rec),
			.left_rec    (l_rec),
			.left_valid  (l_valid),
			.left_before (l_before),
			.right_rec   (r_rec),
			.right_valid (r_valid),
			.rec         (cell_rec[i]),
			.valid       (cell_valid[i]),
			.ahead       (cell_before[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (full) begin
							dropped_q <= 1'b1;
						end
						if (last_record) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_acc && last_of_run) begin
						state_q   <= S_LOAD;
						dropped_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// head cell always holds a record while emitting
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> cell_valid[0])
		else $error("emitting with empty head cell");

	// valid cells form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + 1'b1)) == '0)
		else $error("valid cells not contiguous");

	// chain is empty and the drop flag is cleared after the final record of a set leaves
	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && last_of_run |=> cell_valid == '0 && !dropped_q)
		else $error("chain not cleared after set");

	// a full chain drops the item and flags the set
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && full |=> dropped_q && $stable(cell_valid))
		else $error("dropped item not flagged");

endmodule

### design/rsbk_cell.sv
// rsbk_cell: one cell of the sorting chain, holding a record and its valid bit
// depends on rsbk_pkg
module rsbk_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsbk_pkg::rsbk_ctrl_t  ctrl,
	input  rsbk_pkg::rsbk_rec_t   new_rec,
	input  rsbk_pkg::rsbk_rec_t   left_rec,
	input  logic                  left_valid,
	input  logic                  left_before,
	input  rsbk_pkg::rsbk_rec_t   right_rec,
	input  logic                  right_valid,
	output rsbk_pkg::rsbk_rec_t   rec,
	output logic                  valid,
	output logic                  ahead
);
	import rsbk_pkg::*;

	rsbk_rec_t rec_q;
	logic      valid_q;

	// new item goes ahead of this cell: empty cell or strictly larger key
	assign ahead = !valid_q || (rec_q.price > new_rec.price);
	assign rec   = rec_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.load && ahead) begin
			valid_q <= left_before ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			rec_q <= right_rec;
		end else if (ctrl.load && ahead) begin
			rec_q <= left_before ? left_rec : new_rec;
		end
	end

endmodule
